// File: design/utf16le_to_utf8_transcoder_defines.svh
// Assertion macros shared by the transcoder RTL.
`ifndef UTF16LE_TO_UTF8_TRANSCODER_DEFINES_SVH
`define UTF16LE_TO_UTF8_TRANSCODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define U16U8_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u16u8 check failed");

// next-cycle implication, disabled during reset
`define U16U8_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u16u8 check failed");

`endif

// File: design/u16u8_pkg.sv
// Types, constants and encoding helpers for the UTF-16LE to UTF-8 transcoder.
`default_nettype none

package u16u8_pkg;

  localparam logic [15:0] HiSurrLo  = 16'hD800;
  localparam logic [15:0] LoSurrLo  = 16'hDC00;
  localparam logic [15:0] LoSurrEnd = 16'hE000;
  localparam logic [15:0] BomUnit   = 16'hFEFF;
  localparam logic [20:0] SuppBase  = 21'h10000;

  localparam logic [20:0] Lim1Byte = 21'h80;
  localparam logic [20:0] Lim2Byte = 21'h800;
  localparam logic [20:0] Lim3Byte = 21'h10000;

  localparam logic [1:0] LenM1One   = 2'd0;
  localparam logic [1:0] LenM1Two   = 2'd1;
  localparam logic [1:0] LenM1Three = 2'd2;
  localparam logic [1:0] LenM1Four  = 2'd3;

  localparam logic [2:0] LeadTwo   = 3'b110;
  localparam logic [3:0] LeadThree = 4'b1110;
  localparam logic [4:0] LeadFour  = 5'b11110;
  localparam logic [1:0] ContMark  = 2'b10;

  // job queue between front and back
  localparam int QDepth = 2;
  localparam int PtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW   = $clog2(QDepth + 1);

  // one or two code points to encode for one accepted word
  typedef struct packed {
    logic        two;   // cp_a is a flushed surrogate, cp_b follows
    logic [20:0] cp_a;
    logic [15:0] cp_b;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic held;
  } front_status_t;

  function automatic logic [1:0] utf8_len_m1(logic [20:0] cp);
    logic [1:0] r;
    if (cp < Lim1Byte) begin
      r = LenM1One;
    end else if (cp < Lim2Byte) begin
      r = LenM1Two;
    end else if (cp < Lim3Byte) begin
      r = LenM1Three;
    end else begin
      r = LenM1Four;
    end
    return r;
  endfunction

  // byte idx (0 = lead) of a sequence of lenm1+1 bytes
  function automatic logic [7:0] utf8_byte_at(logic [20:0] cp, logic [1:0] lenm1,
                                              logic [1:0] idx);
    logic [1:0] pos;
    logic [7:0] r;
    pos = lenm1 - idx;
    if (idx == 2'd0) begin
      case (lenm1)
        LenM1One:   r = {1'b0, cp[6:0]};
        LenM1Two:   r = {LeadTwo, cp[10:6]};
        LenM1Three: r = {LeadThree, cp[15:12]};
        default:    r = {LeadFour, cp[20:18]};
      endcase
    end else begin
      case (pos)
        2'd0:    r = {ContMark, cp[5:0]};
        2'd1:    r = {ContMark, cp[11:6]};
        default: r = {ContMark, cp[17:12]};
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/u16u8_front.sv
// Front end: accepts code units, pairs surrogates, drops BOMs, queues jobs.
`default_nettype none

module u16u8_front
  import u16u8_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [15:0]   code_unit_i,
  input  wire logic          starts_text_i,
  input  wire logic          ends_text_i,
  input  wire q_status_t     q_status_i,
  output logic               push_o,
  output job_t               job_o,
  output front_status_t      status_o
);

  logic       held_q, held_d;
  logic [9:0] bits_q, bits_d;
  logic       accept;
  logic       is_high, is_low;
  logic [20:0] flush_cp;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign is_high    = (code_unit_i >= HiSurrLo) && (code_unit_i < LoSurrLo);
  assign is_low     = (code_unit_i >= LoSurrLo) && (code_unit_i < LoSurrEnd);
  assign flush_cp   = {5'b0, HiSurrLo | {6'b0, bits_q}};

  always_comb begin
    push_o = 1'b0;
    job_o  = '0;
    held_d = held_q;
    bits_d = bits_q;
    if (accept) begin
      held_d = 1'b0;
      bits_d = '0;
      if (held_q && !starts_text_i && is_low) begin
        push_o     = 1'b1;
        job_o.cp_a = SuppBase + {1'b0, bits_q, code_unit_i[9:0]};
      end else if (starts_text_i && (code_unit_i == BomUnit)) begin
        push_o     = held_q;
        job_o.cp_a = flush_cp;
      end else if (is_high && !ends_text_i) begin
        held_d     = 1'b1;
        bits_d     = code_unit_i[9:0];
        push_o     = held_q;
        job_o.cp_a = flush_cp;
      end else begin
        push_o = 1'b1;
        if (held_q) begin
          job_o.two  = 1'b1;
          job_o.cp_a = flush_cp;
          job_o.cp_b = code_unit_i;
        end else begin
          job_o.cp_a = {5'b0, code_unit_i};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      bits_q <= '0;
    end else begin
      held_q <= held_d;
      bits_q <= bits_d;
    end
  end

  assign status_o.held = held_q;

endmodule

`default_nettype wire

// File: design/u16u8_fifo.sv
// Short register queue of encode jobs between front and back.
`default_nettype none

module u16u8_fifo
  import u16u8_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire job_t      push_data_i,
  input  wire logic      pop_i,
  output job_t           head_o,
  output q_status_t      status_o
);

  job_t            entries_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign status_o.full  = (count_q == CntW'(QDepth));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = entries_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(QDepth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/u16u8_back.sv
// Back end: head job to output register, one UTF-8 byte per cycle unless stalled.
`default_nettype none

module u16u8_back
  import u16u8_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire job_t       head_i,
  input  wire q_status_t  q_status_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      utf8_byte_o,
  output logic            run_last_o
);

  logic        seg_q, seg_d;
  logic [1:0]  idx_q, idx_d;
  logic        valid_q, valid_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic [20:0] cur_cp;
  logic [1:0]  len_m1;
  logic        seg_end, job_end, advance;

  assign cur_cp  = seg_q ? {5'b0, head_i.cp_b} : head_i.cp_a;
  assign len_m1  = utf8_len_m1(cur_cp);
  assign seg_end = (idx_q == len_m1);
  assign job_end = seg_end && (seg_q || !head_i.two);
  // output register frees up or is being taken this cycle
  assign advance = !q_status_i.empty && (!valid_q || out_ready_i);
  assign pop_o   = advance && job_end;

  always_comb begin
    seg_d   = seg_q;
    idx_d   = idx_q;
    byte_d  = byte_q;
    last_d  = last_q;
    valid_d = valid_q && !out_ready_i;
    if (advance) begin
      valid_d = 1'b1;
      byte_d  = utf8_byte_at(cur_cp, len_m1, idx_q);
      last_d  = job_end;
      if (seg_end) begin
        idx_d = '0;
        seg_d = !job_end;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q   <= 1'b0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      seg_q   <= seg_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign utf8_byte_o = byte_q;
  assign run_last_o  = last_q;

endmodule

`default_nettype wire

// File: design/utf16le_to_utf8_transcoder.sv
// UTF-16LE code unit to UTF-8 byte transcoder, top level.
//
// Input channel (in_valid_i / in_ready_o): one UTF-16 word per handshake with
// starts_text_i / ends_text_i flags. Output channel (out_valid_o /
// out_ready_i): one UTF-8 byte per handshake; run_last_o marks the final byte
// caused by an input word.
// The front end pairs surrogates, drops a leading BOM and pushes an encode job
// into a two-entry queue; the back end emits one byte per cycle, while the
// receiver is ready, from the job at the queue head into an output register.
// A word's job is written into the queue, and its first byte is then built
// from the queue head into the output register. A word yields 1 to 6 bytes
// (1 for ASCII, 3 for a typical BMP character, up to 6 when a held surrogate
// is flushed ahead of a three-byte character).
// Words that only hold a surrogate or drop a BOM produce no bytes.
// When the receiver stalls, the output byte holds, the back end stops, and
// in_ready_o drops once the queue fills. Reset empties the queue and output
// register and clears the held surrogate.
`default_nettype none
`include "utf16le_to_utf8_transcoder_defines.svh"

module utf16le_to_utf8_transcoder
  import u16u8_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] code_unit_i,
  input  wire logic        starts_text_i,
  input  wire logic        ends_text_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       utf8_byte_o,
  output logic             run_last_o
);

  logic          push;
  job_t          push_job;
  job_t          head_job;
  logic          pop;
  q_status_t     q_status;
  front_status_t front_status;

  u16u8_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .code_unit_i   (code_unit_i),
    .starts_text_i (starts_text_i),
    .ends_text_i   (ends_text_i),
    .q_status_i    (q_status),
    .push_o        (push),
    .job_o         (push_job),
    .status_o      (front_status)
  );

  u16u8_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .head_o      (head_job),
    .status_o    (q_status)
  );

  u16u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_job),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .utf8_byte_o (utf8_byte_o),
    .run_last_o  (run_last_o)
  );

  logic in_is_high;
  logic last_high_in;
  logic out_mid;
  assign in_is_high   = (code_unit_i >= HiSurrLo) && (code_unit_i < LoSurrLo);
  assign last_high_in = in_valid_i && in_ready_o && in_is_high && ends_text_i;
  assign out_mid      = out_valid_o && !run_last_o;

  `U16U8_ASSERT_NOW(a_no_push_when_full, clk_i, rst_ni, push, !q_status.full)
  // a byte that is not the last of its word means the job is still queued
  `U16U8_ASSERT_NOW(a_partial_job_queued, clk_i, rst_ni, out_mid, !q_status.empty)
  `U16U8_ASSERT_NEXT(a_last_word_not_held, clk_i, rst_ni, last_high_in, !front_status.held)

endmodule

`default_nettype wire
